// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, codes and types of the session fanout relay table.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int SESSION_SLOTS = 16;
    localparam int MEMBER_SLOTS  = 8;
    localparam int SW = $clog2(SESSION_SLOTS);
    localparam int MW = $clog2(MEMBER_SLOTS);
    localparam int AW = SW + MW;

    localparam logic CMD_JOIN    = 1'b0;
    localparam logic CMD_FORWARD = 1'b1;

    typedef enum logic [2:0] {
        ST_READDR     = 3'd0,
        ST_RENAMED    = 3'd1,
        ST_INSERTED   = 3'd2,
        ST_NO_SESSION = 3'd3,
        ST_NO_MEMBER  = 3'd4,
        ST_FORWARDED  = 3'd5,
        ST_UNKNOWN    = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SSCAN,
        S_SNEW,
        S_JP,
        S_JA,
        S_JF,
        S_FWD,
        S_EMIT,
        S_DONE
    } t_state;

    // controller commands to datapath
    typedef struct packed {
        logic          load;
        logic          sidx_clr;
        logic          sidx_inc;
        logic          midx_clr;
        logic          midx_inc;
        logic          rd;
        logic          sess_new;
        logic          set_addr;
        logic          set_player;
        logic          set_used;
        logic          out_load;
        logic          out_valid;
        logic          out_last;
        t_status       out_status;
    } t_cmd;

    // datapath status to controller
    typedef struct packed {
        logic          is_fwd;
        logic          sidx_end;
        logic          sess_hit;
        logic          rd_ok;      // read data of the current slot is valid
        logic          found_free;
        logic          midx_end;
        logic          rd_used;
        logic          rd_player_eq;
        logic          rd_addr_eq;
        logic          out_busy;
    } t_stat;

endpackage

// File: hw/rtl/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// Sequencer: session scan, member scans for join and forward, result issue.
// ----------------------------------------------------------------------------
module sfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sfr_pkg::t_stat i_stat,
    output sfr_pkg::t_cmd  o_cmd
);
    import sfr_pkg::*;

    t_state r_state, n_state;
    logic   r_pend, n_pend;   // held destination not yet issued

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = '0;
        o_cmd.out_status = ST_FORWARDED;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.sidx_clr = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_SSCAN;
                end
            end
            // one session slot a cycle
            S_SSCAN: begin
                o_cmd.midx_clr = 1'b1;
                if (i_stat.sess_hit) begin
                    n_state = i_stat.is_fwd ? S_FWD : S_JP;
                end else if (i_stat.sidx_end) begin
                    if (i_stat.is_fwd) begin
                        if (!i_stat.out_busy) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = ST_UNKNOWN;
                            n_state = S_IDLE;
                        end
                    end else if (i_stat.found_free) begin
                        n_state = S_SNEW;
                    end else if (!i_stat.out_busy) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_status = ST_NO_SESSION;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.sidx_inc = 1'b1;
                end
            end
            S_SNEW: begin
                o_cmd.sess_new = 1'b1;
                o_cmd.midx_clr = 1'b1;
                n_state = S_JP;
            end
            // join: player match pass
            S_JP: begin
                o_cmd.rd = 1'b1;
                if (!i_stat.rd_ok) begin
                    n_state = S_JP;
                end else if (i_stat.rd_used && i_stat.rd_player_eq) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.set_addr   = 1'b1;
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_status = ST_READDR;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.midx_end) begin
                    o_cmd.midx_clr = 1'b1;
                    n_state = S_JA;
                end else begin
                    o_cmd.midx_inc = 1'b1;
                end
            end
            // join: address match pass
            S_JA: begin
                o_cmd.rd = 1'b1;
                if (!i_stat.rd_ok) begin
                    n_state = S_JA;
                end else if (i_stat.rd_used && i_stat.rd_addr_eq) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.set_player = 1'b1;
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_status = ST_RENAMED;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.midx_end) begin
                    o_cmd.midx_clr = 1'b1;
                    n_state = S_JF;
                end else begin
                    o_cmd.midx_inc = 1'b1;
                end
            end
            // join: first free slot
            S_JF: begin
                o_cmd.rd = 1'b1;
                if (!i_stat.rd_ok) begin
                    n_state = S_JF;
                end else if (!i_stat.rd_used) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.set_used   = 1'b1;
                        o_cmd.set_addr   = 1'b1;
                        o_cmd.set_player = 1'b1;
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_status = ST_INSERTED;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.midx_end) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.out_status = ST_NO_MEMBER;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.midx_inc = 1'b1;
                end
            end
            // forward: request one member read
            S_FWD: begin
                o_cmd.rd = 1'b1;
                n_state = S_EMIT;
            end
            // forward: memory data valid; hold candidate to learn last
            S_EMIT: begin
                if (i_stat.rd_used && !i_stat.rd_addr_eq) begin
                    if (r_pend) begin
                        if (!i_stat.out_busy) begin
                            o_cmd.out_load  = 1'b1;
                            o_cmd.out_valid = 1'b1;
                            n_pend = 1'b1;
                            o_cmd.set_player = 1'b1; // latch new candidate
                            n_state = i_stat.midx_end ? S_DONE : S_FWD;
                            o_cmd.midx_inc = !i_stat.midx_end;
                        end
                    end else begin
                        n_pend = 1'b1;
                        o_cmd.set_player = 1'b1;
                        n_state = i_stat.midx_end ? S_DONE : S_FWD;
                        o_cmd.midx_inc = !i_stat.midx_end;
                    end
                end else begin
                    n_state = i_stat.midx_end ? S_DONE : S_FWD;
                    o_cmd.midx_inc = !i_stat.midx_end;
                end
            end
            // forward: final result
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_last  = 1'b1;
                    o_cmd.out_valid = r_pend;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a forward result issued before the end always had a held candidate
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && o_cmd.out_load) |-> r_pend)
        else $error("issue without held destination");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_cmd.out_load) |=> r_state == S_IDLE)
        else $error("done did not return to idle");

endmodule

// File: hw/rtl/sfr_dp.sv
// ----------------------------------------------------------------------------
// sfr_dp
// Datapath: input hold, session key table, member memory, result register.
// ----------------------------------------------------------------------------
module sfr_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd,
    input  logic [63:0]    i_group_key,
    input  logic [15:0]    i_peer_num,
    input  logic           i_src_is_v6,
    input  logic [15:0]    i_src_port,
    input  logic [63:0]    i_src_ip_hi,
    input  logic [63:0]    i_src_ip_lo,
    input  sfr_pkg::t_cmd  i_ctl,
    output sfr_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_dest_valid,
    output logic           o_dest_is_v6,
    output logic [15:0]    o_dest_port,
    output logic [63:0]    o_dest_ip_hi,
    output logic [63:0]    o_dest_ip_lo,
    output logic [2:0]     o_status,
    output logic           o_last
);
    import sfr_pkg::*;

    localparam int MEMBERS = SESSION_SLOTS * MEMBER_SLOTS;
    localparam int ENTRY_W = 16 + 1 + 16 + 64 + 64;

    // held input item
    logic          r_fwd;
    logic [63:0]   r_key;
    logic [15:0]   r_player;
    logic [ENTRY_W-17:0] r_addr;   // v6, port, hi, lo

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_fwd    <= i_cmd;
            r_key    <= i_group_key;
            r_player <= i_peer_num;
            r_addr   <= {i_src_is_v6, i_src_port,
                         i_src_is_v6 ? i_src_ip_hi : 64'd0,
                         i_src_is_v6 ? i_src_ip_lo : {32'd0, i_src_ip_lo[31:0]}};
        end
    end

    // session table scan
    logic [SESSION_SLOTS-1:0] r_sused;
    logic [63:0]   r_skey [SESSION_SLOTS];
    logic [SW-1:0] r_sidx, r_sfree, r_sess;
    logic          r_has_free;
    logic          w_hit;

    assign w_hit = r_sused[r_sidx] && r_skey[r_sidx] == r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sused <= '0;
        end else if (i_ctl.sess_new) begin
            r_sused[r_sfree] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sess_new) r_skey[r_sfree] <= r_key;
        if (i_ctl.sidx_clr) begin
            r_sidx     <= '0;
            r_has_free <= 1'b0;
        end else begin
            if (!r_sused[r_sidx] && !r_has_free) begin
                r_sfree    <= r_sidx;
                r_has_free <= 1'b1;
            end
            if (i_ctl.sidx_inc) r_sidx <= r_sidx + 1'b1;
        end
        if (w_hit) r_sess <= r_sidx;
        else if (i_ctl.sess_new) r_sess <= r_sfree;
    end

    // member used bits and member memory
    logic [MEMBERS-1:0]  r_mused;
    logic [ENTRY_W-1:0]  r_mem [MEMBERS];
    logic [ENTRY_W-1:0]  r_rdata;
    logic [MW-1:0]       r_midx;
    logic [AW-1:0]       w_maddr;
    logic                w_mused;
    logic                w_found_free;

    assign w_maddr = {r_sess, r_midx};
    assign w_mused = r_mused[w_maddr];
    // a free session exists if seen earlier or at the last slot
    assign w_found_free = r_has_free || !r_sused[r_sidx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mused <= '0;
        end else if (i_ctl.sess_new) begin
            r_mused[{r_sfree, {MW{1'b0}}} +: MEMBER_SLOTS] <= '0;
        end else if (i_ctl.set_used) begin
            r_mused[w_maddr] <= 1'b1;
        end
    end

    // at most one write per join; forward reuses set_player to hold a candidate
    always_ff @(posedge i_clk) begin
        if (!r_fwd && (i_ctl.set_addr || i_ctl.set_player)) begin
            r_mem[w_maddr] <= {i_ctl.set_player ? r_player : r_rdata[ENTRY_W-1 -: 16],
                               i_ctl.set_addr ? r_addr : r_rdata[ENTRY_W-17:0]};
        end
        if (i_ctl.rd) r_rdata <= r_mem[w_maddr];
    end

    // read is registered; join scan compares the data of the current slot
    logic r_rvalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rvalid <= 1'b0;
        else          r_rvalid <= i_ctl.rd && !i_ctl.midx_inc && !i_ctl.midx_clr;
    end

    logic r_rd_used;
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) r_rd_used <= w_mused;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.midx_clr)      r_midx <= '0;
        else if (i_ctl.midx_inc) r_midx <= r_midx + 1'b1;
    end

    // held forward candidate
    logic [ENTRY_W-17:0] r_cand;
    always_ff @(posedge i_clk) begin
        if (r_fwd && i_ctl.set_player) r_cand <= r_rdata[ENTRY_W-17:0];
    end

    // status toward the controller; join states wait for the registered read data
    logic w_data_ok;
    assign w_data_ok = r_fwd || (r_rvalid && r_rd_used == w_mused);

    assign o_stat.is_fwd       = r_fwd;
    assign o_stat.sidx_end     = r_sidx == SW'(SESSION_SLOTS - 1);
    assign o_stat.sess_hit     = w_hit;
    assign o_stat.rd_ok        = w_data_ok;
    assign o_stat.found_free   = w_found_free;
    assign o_stat.midx_end     = r_midx == MW'(MEMBER_SLOTS - 1);
    assign o_stat.rd_used      = r_fwd ? r_rd_used : (w_data_ok ? w_mused : 1'b1);
    assign o_stat.rd_player_eq = w_data_ok && r_rdata[ENTRY_W-1 -: 16] == r_player;
    assign o_stat.rd_addr_eq   = w_data_ok && r_rdata[ENTRY_W-17:0] == r_addr;
    assign o_stat.out_busy     = o_out_valid && !i_out_ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_dest_valid <= i_ctl.out_valid;
            {o_dest_is_v6, o_dest_port, o_dest_ip_hi, o_dest_ip_lo} <=
                i_ctl.out_valid ? r_cand : '0;
            o_status <= i_ctl.out_status;
            o_last   <= i_ctl.out_last;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> !(o_out_valid && !i_out_ready))
        else $error("result overwritten");
    a_new_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.sess_new |-> !r_sused[r_sfree])
        else $error("new session on used slot");
    a_new_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.sess_new |=> r_sused[$past(r_sfree)])
        else $error("session not marked used");

endmodule

// File: hw/rtl/session_fanout_relay_table_unit.sv
// ----------------------------------------------------------------------------
// session_fanout_relay_table_unit
// Session table with member slots: join updates membership, forward lists
// destination addresses of the other members.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  input   | i_in_valid / o_in_ready | i_cmd .. i_src_ip_lo
//  result  | o_out_valid / i_out_ready | o_dest_valid .. o_last
//
//  one item at a time; the accept, then a scan of the session slots (up to 16)
//  join: a new session step if none matched, then up to three member passes
//  (player, address, free slot), each waiting for the registered read data;
//  forward: a read step and an emit step per member slot, then a result step
//  a stalled result register holds the sequencer at its issue point
//  reset clears session and member used bits at once; no clearing pass
module session_fanout_relay_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [63:0] i_group_key,
    input  logic [15:0] i_peer_num,
    input  logic        i_src_is_v6,
    input  logic [15:0] i_src_port,
    input  logic [63:0] i_src_ip_hi,
    input  logic [63:0] i_src_ip_lo,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_dest_valid,
    output logic        o_dest_is_v6,
    output logic [15:0] o_dest_port,
    output logic [63:0] o_dest_ip_hi,
    output logic [63:0] o_dest_ip_lo,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import sfr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // tables and result register
    sfr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_group_key  (i_group_key),
        .i_peer_num   (i_peer_num),
        .i_src_is_v6  (i_src_is_v6),
        .i_src_port   (i_src_port),
        .i_src_ip_hi  (i_src_ip_hi),
        .i_src_ip_lo  (i_src_ip_lo),
        .i_ctl        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_dest_valid (o_dest_valid),
        .o_dest_is_v6 (o_dest_is_v6),
        .o_dest_port  (o_dest_port),
        .o_dest_ip_hi (o_dest_ip_hi),
        .o_dest_ip_lo (o_dest_ip_lo),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
